// ===== hw/rtl/opring_pkg.sv =====
package opring_pkg;

	// Ring geometry and field widths
	localparam int SLOTS      = 1024;
	localparam int ELEM_WIDTH = 64;
	localparam int MAX_READ   = 64;

	localparam int IDX_W  = $clog2(SLOTS);
	localparam int LEN_W  = $clog2(SLOTS + 1);
	localparam int RC_W   = 7;
	localparam int DATA_W = 64;
	localparam int POS_W  = 64;
	localparam int CMP_W  = (LEN_W > RC_W) ? LEN_W : RC_W;

	// Operation codes
	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;
	localparam logic [1:0] OP_END   = 2'd3;

	// Status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_ENDED = 2'd1;
	localparam logic [1:0] ST_BAD   = 2'd2;

	// Sequencer states
	typedef enum logic [1:0] {
		S_IDLE,
		S_CALC,
		S_POS,
		S_STREAM
	} state_t;

	// Source of the reader's new position
	typedef enum logic [1:0] {
		NP_KEEP,
		NP_TOTAL,
		NP_ADV,
		NP_BACK
	} np_sel_t;

	// One result word
	typedef struct packed {
		logic [1:0]        status;
		logic [DATA_W-1:0] read_data;
		logic              data_valid;
		logic [RC_W-1:0]   returned_count;
		logic [POS_W-1:0]  new_position;
		logic [LEN_W-1:0]  stream_length;
		logic              ended;
		logic              last;
	} res_t;

	// Add an offset to a slot index, wrapping once at the ring length
	function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] a,
			input logic [LEN_W-1:0] b, input logic [LEN_W-1:0] len);
		logic [LEN_W:0] s;
		s = (LEN_W + 1)'(a) + (LEN_W + 1)'(b);
		if (s >= (LEN_W + 1)'(len)) begin
			s = s - (LEN_W + 1)'(len);
		end
		return s[IDX_W-1:0];
	endfunction

endpackage

// ===== hw/rtl/opring_ram.sv =====
module opring_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port, registered read port that holds between reads
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/overwriting_packet_ring_with_readers.sv =====
// Channel  Handshake              Word
// -------  ---------------------  -------------------------------------------------
// in       in_valid / in_ready    op, write_data, read_count, from_tail,
//                                 reader_position
// out      out_valid / out_ready  status, read_data, data_valid, returned_count,
//                                 new_position, stream_length, ended, last
// cfg      cfg_wr_en              cfg_wr_data (ring_slots_used), no wait
//
// Write, clear and end take one cycle each and follow back to back while the
// output register drains. A read that fails is answered the same way; otherwise
// it passes S_CALC and S_POS for count and position arithmetic, then streams one
// word per cycle unless out stalls, paced by the slot memory's single read port.
// Reset clears the pointers, counters and flags; the slot memory is not cleared.
// A stall on out holds the output register and the memory's read data.
module overwriting_packet_ring_with_readers
	import opring_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,

	input  logic              cfg_wr_en,
	input  logic [LEN_W-1:0]  cfg_wr_data,

	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        op,
	input  logic [DATA_W-1:0] write_data,
	input  logic [RC_W-1:0]   read_count,
	input  logic              from_tail,
	input  logic [POS_W-1:0]  reader_position,

	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        status,
	output logic [DATA_W-1:0] read_data,
	output logic              data_valid,
	output logic [RC_W-1:0]   returned_count,
	output logic [POS_W-1:0]  new_position,
	output logic [LEN_W-1:0]  stream_length,
	output logic              ended,
	output logic              last
);

	// Ring state
	logic [LEN_W-1:0] len_q;
	logic [IDX_W-1:0] first_q;
	logic [LEN_W-1:0] fill_q;
	logic [POS_W-1:0] total_q;
	logic             ended_q;
	state_t           state_q, state_nx;

	// Read context
	logic [POS_W-1:0] pos_q;
	logic [RC_W-1:0]  want_q;
	logic             tail_q;
	logic [POS_W-1:0] remain_q;
	logic             borrow_q;
	logic [RC_W-1:0]  n_q;
	logic [IDX_W-1:0] src_q;
	np_sel_t          np_sel_q;
	logic [POS_W-1:0] newpos_q;
	logic [RC_W-1:0]  k_q;
	logic [IDX_W-1:0] rd_idx_q;
	logic             pend_q;
	logic             pend_last_q;

	// Output register
	res_t             out_q;
	logic             out_valid_q;

	// Control
	logic             out_free;
	logic             accept;
	logic             bad;
	logic             start_read;
	logic             move;
	logic             issue;
	logic             emit_empty;
	logic             done;
	logic             load_out;
	res_t             res_nx;
	res_t             imm_res;

	// Write path
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	logic [ELEM_WIDTH-1:0] ram_rdata;
	logic [LEN_W-1:0] fill_nx;
	logic [IDX_W-1:0] first_nx;

	// Calc stage
	logic [RC_W-1:0]  n0;
	logic [RC_W-1:0]  n_calc;
	logic [IDX_W-1:0] src_calc;
	np_sel_t          np_calc;
	logic             ahead;
	logic             rem_hi_zero;
	logic [LEN_W-1:0] rem_lo;
	logic             rem_small;
	logic             rem_le;
	logic [RC_W-1:0]  want_clamp;
	logic [POS_W:0]   diff;
	logic [POS_W-1:0] newpos_calc;
	logic [LEN_W-1:0] cur_len_out;

	assign out_free = !out_valid_q || out_ready;
	assign bad      = (LEN_W'(first_q) >= len_q) || (fill_q > len_q);
	assign accept   = in_valid && in_ready;
	assign cur_len_out = ended_q ? '0 : fill_q;

	// Control outputs of the sequencer
	always_comb begin
		in_ready   = 1'b0;
		start_read = 1'b0;
		move       = 1'b0;
		issue      = 1'b0;
		emit_empty = 1'b0;
		done       = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready   = out_free;
				start_read = in_valid && out_free && (op == OP_READ)
					&& (read_count != '0) && !ended_q && !bad;
			end
			S_STREAM: begin
				if (n_q == '0) begin
					emit_empty = out_free;
					done       = out_free;
				end else begin
					move  = pend_q && out_free;
					issue = (k_q < n_q) && (!pend_q || move);
					done  = move && pend_last_q;
				end
			end
			default: begin
			end
		endcase
	end

	// Next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_IDLE:   if (start_read) state_nx = S_CALC;
			S_CALC:   state_nx = S_POS;
			S_POS:    state_nx = S_STREAM;
			S_STREAM: if (done) state_nx = S_IDLE;
			default:  state_nx = S_IDLE;
		endcase
	end

	// Ring update for a write
	always_comb begin
		ram_waddr = wrap_add(first_q, fill_q, len_q);
		fill_nx   = fill_q;
		first_nx  = first_q;
		if (fill_q < len_q) begin
			fill_nx = fill_q + LEN_W'(1);
		end else begin
			first_nx = wrap_add(first_q, LEN_W'(1), len_q);
		end
	end

	assign ram_we = accept && (op == OP_WRITE) && !bad;

	// Single-word result of the accepted item
	always_comb begin
		imm_res                = '0;
		imm_res.last           = 1'b1;
		imm_res.ended          = ended_q;
		imm_res.stream_length  = cur_len_out;
		case (op)
			OP_WRITE: begin
				if (bad) begin
					imm_res.status = ST_BAD;
				end else begin
					imm_res.stream_length = ended_q ? '0 : fill_nx;
				end
			end
			OP_READ: begin
				imm_res.new_position = reader_position;
				if (read_count == '0 || (!ended_q && bad)) begin
					imm_res.status = ST_BAD;
				end else if (ended_q) begin
					imm_res.status = ST_ENDED;
				end
			end
			OP_CLEAR: begin
				imm_res.stream_length = '0;
			end
			OP_END: begin
				imm_res.ended         = 1'b1;
				imm_res.stream_length = '0;
			end
			default: begin
			end
		endcase
	end

	assign want_clamp = (read_count > RC_W'(MAX_READ)) ? RC_W'(MAX_READ) : read_count;
	assign diff       = {1'b0, total_q} - {1'b0, reader_position};

	// Count, start slot and position mode of a read
	always_comb begin
		rem_hi_zero = ~|remain_q[POS_W-1:LEN_W];
		rem_lo      = remain_q[LEN_W-1:0];
		rem_small   = rem_hi_zero && (rem_lo < fill_q);
		rem_le      = rem_hi_zero && (rem_lo <= fill_q);
		ahead       = borrow_q || (remain_q == '0);
		n0          = (CMP_W'(want_q) < CMP_W'(fill_q)) ? want_q : RC_W'(fill_q);
		n_calc      = n0;
		src_calc    = first_q;
		np_calc     = NP_KEEP;
		if (n0 != '0) begin
			if (tail_q) begin
				src_calc = wrap_add(first_q, fill_q - LEN_W'(n0), len_q);
				np_calc  = NP_TOTAL;
			end else if (!ahead) begin
				if (rem_small) begin
					if (CMP_W'(rem_lo) < CMP_W'(n0)) begin
						n_calc = RC_W'(rem_lo);
					end
					src_calc = wrap_add(first_q, fill_q - rem_lo, len_q);
				end
				np_calc = rem_le ? NP_ADV : NP_BACK;
			end else begin
				n_calc = '0;
			end
		end
	end

	// New reader position
	always_comb begin
		case (np_sel_q)
			NP_TOTAL: newpos_calc = total_q;
			NP_ADV:   newpos_calc = pos_q + POS_W'(n_q);
			NP_BACK:  newpos_calc = total_q - POS_W'(fill_q - LEN_W'(n_q));
			default:  newpos_calc = pos_q;
		endcase
	end

	// Select what enters the output register
	always_comb begin
		load_out = 1'b0;
		res_nx   = imm_res;
		if (accept && !start_read) begin
			load_out = 1'b1;
		end else if (emit_empty) begin
			load_out            = 1'b1;
			res_nx              = '0;
			res_nx.new_position = newpos_q;
			res_nx.stream_length = cur_len_out;
			res_nx.ended        = ended_q;
			res_nx.last         = 1'b1;
		end else if (move) begin
			load_out              = 1'b1;
			res_nx.status         = ST_OK;
			res_nx.read_data      = DATA_W'(ram_rdata);
			res_nx.data_valid     = 1'b1;
			res_nx.returned_count = n_q;
			res_nx.new_position   = newpos_q;
			res_nx.stream_length  = cur_len_out;
			res_nx.ended          = ended_q;
			res_nx.last           = pend_last_q;
		end
	end

	opring_ram #(
		.WIDTH(ELEM_WIDTH),
		.DEPTH(SLOTS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(write_data[ELEM_WIDTH-1:0]),
		.re   (issue),
		.raddr(rd_idx_q),
		.rdata(ram_rdata)
	);

	// Control state and ring pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			len_q       <= LEN_W'(SLOTS);
			first_q     <= '0;
			fill_q      <= '0;
			total_q     <= '0;
			ended_q     <= 1'b0;
			pend_q      <= 1'b0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			// Saturate the slot count into 1..SLOTS
			if (cfg_wr_en) begin
				if (cfg_wr_data == '0) begin
					len_q <= LEN_W'(1);
				end else if (cfg_wr_data > LEN_W'(SLOTS)) begin
					len_q <= LEN_W'(SLOTS);
				end else begin
					len_q <= cfg_wr_data;
				end
			end
			if (ram_we) begin
				fill_q  <= fill_nx;
				first_q <= first_nx;
				total_q <= total_q + POS_W'(1);
			end
			if (accept && op == OP_CLEAR) begin
				first_q <= '0;
				fill_q  <= '0;
			end
			if (accept && op == OP_END) begin
				ended_q <= 1'b1;
			end
			// Track issued memory reads
			if (state_q == S_POS) begin
				k_q <= '0;
			end else if (issue) begin
				k_q <= k_q + RC_W'(1);
			end
			if (issue) begin
				pend_q <= 1'b1;
			end else if (move) begin
				pend_q <= 1'b0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Read context and output word
	always_ff @(posedge clk) begin
		if (start_read) begin
			pos_q    <= reader_position;
			want_q   <= want_clamp;
			tail_q   <= from_tail;
			remain_q <= diff[POS_W-1:0];
			borrow_q <= diff[POS_W];
		end
		if (state_q == S_CALC) begin
			n_q      <= n_calc;
			src_q    <= src_calc;
			np_sel_q <= np_calc;
		end
		if (state_q == S_POS) begin
			newpos_q <= newpos_calc;
			rd_idx_q <= src_q;
		end else if (issue) begin
			rd_idx_q <= wrap_add(rd_idx_q, LEN_W'(1), len_q);
		end
		if (issue) begin
			pend_last_q <= (k_q + RC_W'(1)) == n_q;
		end
		if (load_out) begin
			out_q <= res_nx;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = out_q.status;
	assign read_data      = out_q.read_data;
	assign data_valid     = out_q.data_valid;
	assign returned_count = out_q.returned_count;
	assign new_position   = out_q.new_position;
	assign stream_length  = out_q.stream_length;
	assign ended          = out_q.ended;
	assign last           = out_q.last;

endmodule

// ===== tb/opring_checker.sv =====
module opring_checker
	import opring_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,

	input  logic              cfg_wr_en,
	input  logic [LEN_W-1:0]  cfg_wr_data,

	input  logic              in_valid,
	input  logic              in_ready,
	input  logic [1:0]        op,
	input  logic [DATA_W-1:0] write_data,
	input  logic [RC_W-1:0]   read_count,
	input  logic              from_tail,
	input  logic [POS_W-1:0]  reader_position,

	input  logic              out_valid,
	input  logic              out_ready,
	input  logic [1:0]        status,
	input  logic [DATA_W-1:0] read_data,
	input  logic              data_valid,
	input  logic [RC_W-1:0]   returned_count,
	input  logic [POS_W-1:0]  new_position,
	input  logic [LEN_W-1:0]  stream_length,
	input  logic              ended,
	input  logic              last,

	output int                fails,
	output int                words_owed
);
	timeunit 1ns;
	timeprecision 1ps;

	// Shadow copy of the ring and its bookkeeping
	logic [DATA_W-1:0] slot_copy [SLOTS];
	int unsigned       ring_len;
	int unsigned       head;
	int unsigned       fill;
	logic [POS_W-1:0]  total;
	bit                is_ended;
	res_t              answer_q [$];

	// Step an offset around the ring, one subtraction at most
	function automatic int unsigned ring_idx(input int unsigned base, input int unsigned off,
			input int unsigned len);
		int unsigned s;
		s = base + off;
		if (s >= len) begin
			s = s - len;
		end
		return s;
	endfunction

	// Queue one expected output word, with the length and flag as they stand now
	function automatic void push_answer(input logic [1:0] st, input logic [DATA_W-1:0] d,
			input logic dv, input int unsigned cnt, input logic [POS_W-1:0] np,
			input logic lst);
		res_t w;
		w.status         = st;
		w.read_data      = d;
		w.data_valid     = dv;
		w.returned_count = RC_W'(cnt);
		w.new_position   = np;
		w.stream_length  = is_ended ? '0 : LEN_W'(fill);
		w.ended          = is_ended;
		w.last           = lst;
		answer_q.push_back(w);
	endfunction

	function automatic string word_text(input res_t w);
		return $sformatf("st=%0d data=%h dv=%b cnt=%0d pos=%h len=%0d end=%b last=%b",
			w.status, w.read_data, w.data_valid, w.returned_count, w.new_position,
			w.stream_length, w.ended, w.last);
	endfunction

	// Apply one accepted input word to the shadow ring and queue its answers
	task automatic model_ring_op(input logic [1:0] code, input logic [DATA_W-1:0] wd,
			input logic [RC_W-1:0] cnt, input logic tl, input logic [POS_W-1:0] rp);
		int unsigned      len;
		int unsigned      want;
		int unsigned      n;
		int unsigned      src;
		int unsigned      k;
		bit               broken;
		logic [POS_W-1:0] newpos;
		logic [POS_W-1:0] remain;
		len    = (ring_len == 0) ? 1 : ((ring_len > SLOTS) ? SLOTS : ring_len);
		broken = (head >= len) || (fill > len);
		want   = 32'(cnt);
		case (code)
			OP_WRITE: begin
				if (broken) begin
					push_answer(ST_BAD, '0, 1'b0, 0, '0, 1'b1);
				end else begin
					slot_copy[ring_idx(head, fill, len)] = wd;
					// grow until full, then drop the oldest
					if (fill < len) begin
						fill++;
					end else begin
						head = ring_idx(head, 1, len);
					end
					total++;
					push_answer(ST_OK, '0, 1'b0, 0, '0, 1'b1);
				end
			end
			OP_CLEAR: begin
				head = 0;
				fill = 0;
				push_answer(ST_OK, '0, 1'b0, 0, '0, 1'b1);
			end
			OP_END: begin
				is_ended = 1'b1;
				push_answer(ST_OK, '0, 1'b0, 0, '0, 1'b1);
			end
			default: begin
				if (want == 0 || (!is_ended && broken)) begin
					push_answer(ST_BAD, '0, 1'b0, 0, rp, 1'b1);
				end else if (is_ended) begin
					push_answer(ST_ENDED, '0, 1'b0, 0, rp, 1'b1);
				end else begin
					if (want > MAX_READ) begin
						want = MAX_READ;
					end
					n      = (want < fill) ? want : fill;
					src    = head;
					newpos = rp;
					if (n > 0) begin
						if (tl) begin
							// newest n packets
							src    = ring_idx(head, fill - n, len);
							newpos = total;
						end else if (total > rp) begin
							// packets after the reader; a lagging reader skips to the oldest
							remain = total - rp;
							if (remain < fill) begin
								if (remain < n) begin
									n = remain[31:0];
								end
								src = ring_idx(head, fill - remain[31:0], len);
							end
							if (total - fill <= rp) begin
								newpos = rp + n;
							end else begin
								newpos = total - (fill - n);
							end
						end else begin
							n = 0;
						end
					end
					if (n == 0) begin
						push_answer(ST_OK, '0, 1'b0, 0, newpos, 1'b1);
					end else begin
						for (k = 0; k < n; k++) begin
							push_answer(ST_OK, slot_copy[ring_idx(src, k, len)], 1'b1, n,
								newpos, k + 1 == n);
						end
					end
				end
			end
		endcase
	endtask

	// Compare one delivered output word with the oldest expectation
	task automatic check_word();
		res_t got;
		res_t exp_w;
		got = '{status, read_data, data_valid, returned_count, new_position,
			stream_length, ended, last};
		if (answer_q.size() == 0) begin
			fails++;
			if (fails <= 10) begin
				$display("ERROR: output word with nothing pending: %s", word_text(got));
			end
		end else begin
			exp_w = answer_q.pop_front();
			if (got !== exp_w) begin
				fails++;
				if (fails <= 10) begin
					$display("ERROR: output word mismatch at %0t", $realtime);
					$display("  expected %s", word_text(exp_w));
					$display("  actual   %s", word_text(got));
				end
			end
		end
	endtask

	// Track config writes, accepted inputs and delivered outputs
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_len = SLOTS;
			head     = 0;
			fill     = 0;
			total    = '0;
			is_ended = 1'b0;
			answer_q.delete();
			fails      = 0;
			words_owed = 0;
		end else begin
			if (cfg_wr_en) begin
				ring_len = 32'(cfg_wr_data);
			end
			if (in_valid && in_ready) begin
				model_ring_op(op, write_data, read_count, from_tail, reader_position);
			end
			if (out_valid && out_ready) begin
				check_word();
			end
			words_owed = answer_q.size();
		end
	end

endmodule

// ===== tb/tb_overwriting_packet_ring_with_readers.sv =====
module tb_overwriting_packet_ring_with_readers;
	timeunit 1ns;
	timeprecision 1ps;

	import opring_pkg::*;

	localparam int HOLD_CYCLES = 400;
	localparam int PHASES      = 11;

	logic              clk             = 1'b0;
	logic              arst_n          = 1'b0;
	logic              cfg_wr_en       = 1'b0;
	logic [LEN_W-1:0]  cfg_wr_data     = '0;
	logic              in_valid        = 1'b0;
	logic              in_ready;
	logic [1:0]        op              = OP_WRITE;
	logic [DATA_W-1:0] write_data      = '0;
	logic [RC_W-1:0]   read_count      = '0;
	logic              from_tail       = 1'b0;
	logic [POS_W-1:0]  reader_position = '0;
	logic              out_valid;
	logic              out_ready       = 1'b0;
	logic [1:0]        status;
	logic [DATA_W-1:0] read_data;
	logic              data_valid;
	logic [RC_W-1:0]   returned_count;
	logic [POS_W-1:0]  new_position;
	logic [LEN_W-1:0]  stream_length;
	logic              ended;
	logic              last;

	int                fails;
	int                words_owed;

	// Stimulus bookkeeping
	bit                calm_sender   = 1'b0;
	bit                hold_req      = 1'b0;
	longint unsigned   words_written = 0;
	int unsigned       len_now       = SLOTS;
	int                n_writes      = 0;
	int                n_reads       = 0;
	int                n_clears      = 0;
	int                n_ends        = 0;
	int                n_settings    = 0;

	overwriting_packet_ring_with_readers u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.op              (op),
		.write_data      (write_data),
		.read_count      (read_count),
		.from_tail       (from_tail),
		.reader_position (reader_position),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.status          (status),
		.read_data       (read_data),
		.data_valid      (data_valid),
		.returned_count  (returned_count),
		.new_position    (new_position),
		.stream_length   (stream_length),
		.ended           (ended),
		.last            (last)
	);

	opring_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.op              (op),
		.write_data      (write_data),
		.read_count      (read_count),
		.from_tail       (from_tail),
		.reader_position (reader_position),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.status          (status),
		.read_data       (read_data),
		.data_valid      (data_valid),
		.returned_count  (returned_count),
		.new_position    (new_position),
		.stream_length   (stream_length),
		.ended           (ended),
		.last            (last),
		.fails           (fails),
		.words_owed      (words_owed)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Mostly short gaps, now and then a long one
	function automatic int gap_cycles(input bit calm);
		int r;
		if (calm) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end
		if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(6, 30);
	endfunction

	// Ring sizes visited by the random phases, extremes included
	function automatic logic [LEN_W-1:0] plan_slots(input int ph);
		case (ph)
			0:       return LEN_W'(1);
			1:       return LEN_W'(0);
			2:       return LEN_W'(5);
			3:       return LEN_W'(2047);
			4:       return LEN_W'(3);
			5:       return LEN_W'(16);
			6:       return LEN_W'(7);
			7:       return LEN_W'(1024);
			8:       return LEN_W'(2);
			9:       return LEN_W'(12);
			default: return LEN_W'(4);
		endcase
	endfunction

	// Reader positions around the running total: behind, level, ahead, anywhere
	function automatic logic [POS_W-1:0] pick_pos();
		int              r;
		longint unsigned back;
		r    = $urandom_range(0, 99);
		back = $urandom_range(0, 2 * len_now + 3);
		if (r < 50) begin
			return (back > words_written) ? '0 : words_written - back;
		end
		if (r < 65) begin
			return words_written + $urandom_range(0, 3);
		end
		if (r < 85) begin
			return {$urandom, $urandom};
		end
		if (r < 93) begin
			return '0;
		end
		return '1;
	endfunction

	// Offer one input word and hold it until the handshake completes
	task automatic offer_word(input logic [1:0] w_op, input logic [DATA_W-1:0] w_data,
			input logic [RC_W-1:0] w_cnt, input logic w_tail, input logic [POS_W-1:0] w_pos);
		int gap;
		gap = gap_cycles(calm_sender);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid        <= 1'b1;
		op              <= w_op;
		write_data      <= w_data;
		read_count      <= w_cnt;
		from_tail       <= w_tail;
		reader_position <= w_pos;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		case (w_op)
			OP_WRITE: begin
				n_writes++;
				words_written++;
			end
			OP_READ:  n_reads++;
			OP_CLEAR: n_clears++;
			default:  n_ends++;
		endcase
	endtask

	// One random word: mostly writes and reads, some clears, bad counts and, if allowed, ends
	task automatic random_word(input bit allow_end);
		int              r;
		logic [RC_W-1:0] cnt;
		r = $urandom_range(0, 99);
		case ($urandom_range(0, 9))
			0:       cnt = RC_W'($urandom_range(MAX_READ + 1, 127));
			1:       cnt = RC_W'($urandom_range(1, 4));
			default: cnt = RC_W'($urandom_range(1, MAX_READ));
		endcase
		if (allow_end && r < 8) begin
			offer_word(OP_END, {$urandom, $urandom}, cnt, 1'($urandom), pick_pos());
		end else if (r < 50) begin
			offer_word(OP_WRITE, {$urandom, $urandom}, cnt, 1'($urandom), pick_pos());
		end else if (r < 54) begin
			offer_word(OP_CLEAR, {$urandom, $urandom}, cnt, 1'($urandom), pick_pos());
		end else if (r < 58) begin
			offer_word(OP_READ, {$urandom, $urandom}, '0, 1'($urandom), pick_pos());
		end else begin
			offer_word(OP_READ, {$urandom, $urandom}, cnt, $urandom_range(0, 99) < 40,
				pick_pos());
		end
	endtask

	// Drop valid, wait until every answer is back, then let the pipe settle
	task automatic drain_ring();
		in_valid <= 1'b0;
		do begin
			@(negedge clk);
		end while (words_owed != 0);
		repeat (8) @(posedge clk);
	endtask

	// Change the ring size while the block is idle
	task automatic set_slots(input logic [LEN_W-1:0] slots_cfg);
		drain_ring();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= slots_cfg;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		n_settings++;
		len_now = (slots_cfg == 0) ? 1 : ((slots_cfg > SLOTS) ? SLOTS : slots_cfg);
	endtask

	// Receiver: random stalls, steady stretches, and one long hold-off on request
	initial begin
		@(posedge clk);
		forever begin
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req <= 1'b0;
				out_ready <= 1'b1;
				repeat (4) @(posedge clk);
			end else if ($urandom_range(0, 3) == 0) begin
				out_ready <= 1'b1;
				repeat ($urandom_range(16, 96)) @(posedge clk);
			end else begin
				out_ready <= 1'b0;
				repeat (gap_cycles(1'b0) + 1) @(posedge clk);
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
	end

	// Stimulus
	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: full-size ring after reset
		offer_word(OP_READ,  '0, RC_W'(5), 1'b1, '1);
		offer_word(OP_WRITE, '1, '0, 1'b0, '0);
		offer_word(OP_WRITE, '0, '1, 1'b1, '1);
		offer_word(OP_WRITE, 64'h0123_4567_89AB_CDEF, '0, 1'b0, '0);
		offer_word(OP_READ,  '0, '0, 1'b1, POS_W'(7));
		offer_word(OP_READ,  '0, RC_W'(127), 1'b1, '0);
		offer_word(OP_READ,  '0, RC_W'(1), 1'b1, '0);
		offer_word(OP_READ,  '0, RC_W'(2), 1'b0, POS_W'(0));
		offer_word(OP_READ,  '0, RC_W'(64), 1'b0, POS_W'(2));
		offer_word(OP_READ,  '0, RC_W'(3), 1'b0, POS_W'(3));
		offer_word(OP_READ,  '0, RC_W'(64), 1'b0, '1);
		offer_word(OP_CLEAR, '0, '0, 1'b0, '0);
		offer_word(OP_READ,  '0, RC_W'(64), 1'b1, POS_W'(9));

		// Directed: two slots, overwrite and a lagging reader
		set_slots(LEN_W'(2));
		offer_word(OP_CLEAR, '0, '0, 1'b0, '0);
		offer_word(OP_WRITE, 64'hA5A5_A5A5_A5A5_A5A5, '0, 1'b0, '0);
		offer_word(OP_WRITE, 64'h5A5A_5A5A_5A5A_5A5A, '0, 1'b0, '0);
		offer_word(OP_WRITE, 64'h3C3C_3C3C_3C3C_3C3C, '0, 1'b0, '0);
		offer_word(OP_READ,  '0, RC_W'(64), 1'b0, POS_W'(0));

		// Directed: shrink without clearing leaves the pointers out of range
		set_slots(LEN_W'(1));
		offer_word(OP_WRITE, 64'hDEAD_BEEF_0000_0001, '0, 1'b0, '0);
		offer_word(OP_READ,  '0, RC_W'(4), 1'b1, POS_W'(11));
		offer_word(OP_CLEAR, '0, '0, 1'b0, '0);
		offer_word(OP_WRITE, 64'h0000_0001_FEED_F00D, '0, 1'b0, '0);
		offer_word(OP_READ,  '0, RC_W'(3), 1'b1, '0);

		// Random phases, one ring size each, cleared before use
		for (int ph = 0; ph < PHASES; ph++) begin
			set_slots(plan_slots(ph));
			calm_sender = ($urandom_range(0, 3) == 0);
			offer_word(OP_CLEAR, {$urandom, $urandom}, '0, 1'b0, '0);
			if (ph == 4) begin
				// hold off the receiver while words keep coming
				calm_sender = 1'b1;
				hold_req <= 1'b1;
				repeat (40) offer_word(OP_WRITE, {$urandom, $urandom}, '0, 1'b0, '0);
				calm_sender = 1'b0;
			end
			repeat (20) random_word(1'b0);
		end

		// End of stream: reads refuse, writes still land
		calm_sender = 1'b0;
		offer_word(OP_END,   '0, '0, 1'b0, '0);
		offer_word(OP_READ,  '0, '0, 1'b0, '1);
		offer_word(OP_READ,  '0, RC_W'(4), 1'b1, '0);
		offer_word(OP_WRITE, '1, '0, 1'b0, '0);
		repeat (20) random_word(1'b1);

		drain_ring();
		repeat (24) @(posedge clk);
		$display("Summary: %0d words in (%0d writes, %0d reads, %0d clears, %0d ends), %0d sizes",
			n_writes + n_reads + n_clears + n_ends, n_writes, n_reads, n_clears, n_ends,
			n_settings);
		$display("Summary: one %0d-cycle receiver hold-off under load, %0d mismatches",
			HOLD_CYCLES, fails);
		if (fails == 0 && words_owed == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#20_000_000;
		$display("Timeout: %0d words still owed", words_owed);
		$display("Test completed with failures");
		$finish;
	end

endmodule
